### rtl/core/gru_pkg.sv
// ----------------------------------------------------------------------------
// gru_pkg
// Shared types and constants of the Givens rotation unit.
// ----------------------------------------------------------------------------
package gru_pkg;

    localparam int COEF_FRAC = 30;
    localparam int TM_W      = 31;  // ratio magnitude, Q0.30, up to 2^30
    localparam int DIV_STEPS = 31;  // quotient bits of the ratio divide
    localparam int DIV_W     = 62;  // datapath width of both dividers
    localparam int SQ_IN_W   = 64;  // radicand width
    localparam int SQ_STEPS  = 32;  // root bits
    localparam int K_STEPS   = 31;  // quotient bits of 2^61 / r

    localparam logic signed [31:0] COEF_ONE = 32'sh4000_0000;

    typedef enum logic {
        MODE_APPLY = 1'b0,
        MODE_GEN   = 1'b1
    } t_mode;

    // item carried beside the generator pipeline
    typedef struct packed {
        logic               gen;   // generate mode
        logic               yzero; // y is zero
        logic               ybig;  // |y| > |x|
        logic               neg;   // signs differ and small is nonzero
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] c;
        logic signed [31:0] s;
    } t_item;

endpackage

### rtl/core/gru_div_stage.sv
// ----------------------------------------------------------------------------
// gru_div_stage
// One registered restoring-divide step, shared form for all dividers.
// ----------------------------------------------------------------------------
module gru_div_stage
    import gru_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [DIV_W-1:0] i_rem,
    input  logic [DIV_W-1:0] i_den,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_quo,
    input  t_item            i_item,
    input  logic [TM_W-1:0]  i_aux,
    output logic             o_valid,
    output logic [DIV_W-1:0] o_rem,
    output logic [DIV_W-1:0] o_den,
    output logic [DIV_W-1:0] o_num,
    output logic [DIV_W-1:0] o_quo,
    output t_item            o_item,
    output logic [TM_W-1:0]  o_aux
);

    logic [DIV_W:0] n_trial;
    logic [DIV_W:0] n_diff;

    // shift in one numerator bit and try to subtract
    always_comb begin
        n_trial = {i_rem, i_num[DIV_W-1]};
        n_diff  = n_trial - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!n_diff[DIV_W]) begin
                o_rem <= n_diff[DIV_W-1:0];
            end else begin
                o_rem <= n_trial[DIV_W-1:0];
            end
            o_quo  <= {i_quo[DIV_W-2:0], ~n_diff[DIV_W]};
            o_num  <= {i_num[DIV_W-2:0], 1'b0};
            o_den  <= i_den;
            o_item <= i_item;
            o_aux  <= i_aux;
        end
    end

endmodule

### rtl/core/gru_sqrt_stage.sv
// ----------------------------------------------------------------------------
// gru_sqrt_stage
// One registered digit step of the integer square root.
// ----------------------------------------------------------------------------
module gru_sqrt_stage
    import gru_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [SQ_IN_W-1:0] i_rad,
    input  logic [33:0]        i_rem,
    input  logic [31:0]        i_root,
    input  t_item              i_item,
    input  logic [TM_W-1:0]    i_tm,
    output logic               o_valid,
    output logic [SQ_IN_W-1:0] o_rad,
    output logic [33:0]        o_rem,
    output logic [31:0]        o_root,
    output t_item              o_item,
    output logic [TM_W-1:0]    o_tm
);

    logic [33:0] n_trial_rem;
    logic [34:0] n_diff;

    // bring down two radicand bits, trial subtract 4*root+1
    always_comb begin
        n_trial_rem = {i_rem[31:0], i_rad[SQ_IN_W-1 -: 2]};
        n_diff      = {1'b0, n_trial_rem} - {1'b0, i_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!n_diff[34]) begin
                o_rem <= n_diff[33:0];
            end else begin
                o_rem <= n_trial_rem;
            end
            o_root <= {i_root[30:0], ~n_diff[34]};
            o_rad  <= {i_rad[SQ_IN_W-3:0], 2'b00};
            o_item <= i_item;
            o_tm   <= i_tm;
        end
    end

endmodule

### rtl/core/gru_coef_gen.sv
// ----------------------------------------------------------------------------
// gru_coef_gen
// Pipelined coefficient generator: ratio divide, square root, reciprocal,
// final product. Items in apply mode ride along unchanged.
// ----------------------------------------------------------------------------
module gru_coef_gen
    import gru_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_valid,
    output t_item       o_item
);

    localparam int DW = DIV_W;  // width of the ratio divide
    localparam int KW = DIV_W;  // width of the reciprocal divide

    // ---- stage 0: magnitudes and order
    logic        n_ybig;
    logic [31:0] n_ax, n_ay;
    logic [31:0] n_big, n_sml;
    t_item       n_s0_item;
    logic        r_s0_valid;
    t_item       r_s0_item;
    logic [31:0] r_s0_big, r_s0_sml;

    always_comb begin
        n_ax   = i_item.x[31] ? 32'(-i_item.x) : i_item.x;
        n_ay   = i_item.y[31] ? 32'(-i_item.y) : i_item.y;
        n_ybig = n_ay > n_ax;
        n_big  = n_ybig ? n_ay : n_ax;
        n_sml  = n_ybig ? n_ax : n_ay;
        n_s0_item       = i_item;
        n_s0_item.yzero = (i_item.y == 32'sd0);
        n_s0_item.ybig  = n_ybig;
        n_s0_item.neg   = (i_item.x[31] != i_item.y[31]) && (n_sml != 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (i_en) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0_item <= n_s0_item;
            r_s0_big  <= n_big;
            r_s0_sml  <= n_sml;
        end
    end

    // ---- ratio divide: tm = (sml << 30) / big, last 31 quotient bits
    logic          d_v   [DIV_STEPS+1];
    logic [DW-1:0] d_rem [DIV_STEPS+1];
    logic [DW-1:0] d_den [DIV_STEPS+1];
    logic [DW-1:0] d_num [DIV_STEPS+1];
    logic [DW-1:0] d_quo [DIV_STEPS+1];
    t_item         d_it  [DIV_STEPS+1];
    logic [TM_W-1:0] d_aux [DIV_STEPS+1];

    // the top 31 numerator bits form sml >> 1, which is below big, so they
    // give zero quotient digits; start the remainder there and feed sml[0]
    // followed by the 30 fraction zeros
    always_comb begin
        d_v[0]   = r_s0_valid;
        d_rem[0] = {31'd0, r_s0_sml[31:1]};
        d_den[0] = {30'd0, (r_s0_big == 32'd0) ? 32'd1 : r_s0_big};
        d_num[0] = {r_s0_sml[0], 30'd0, 31'd0};
        d_quo[0] = '0;
        d_it[0]  = r_s0_item;
        d_aux[0] = '0;
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        gru_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (d_v[g]),
            .i_rem   (d_rem[g]),
            .i_den   (d_den[g]),
            .i_num   (d_num[g]),
            .i_quo   (d_quo[g]),
            .i_item  (d_it[g]),
            .i_aux   (d_aux[g]),
            .o_valid (d_v[g+1]),
            .o_rem   (d_rem[g+1]),
            .o_den   (d_den[g+1]),
            .o_num   (d_num[g+1]),
            .o_quo   (d_quo[g+1]),
            .o_item  (d_it[g+1]),
            .o_aux   (d_aux[g+1])
        );
    end

    // ---- square: radicand = (2^60 + tm*tm) * 4
    logic [TM_W-1:0]    q_tm;
    logic [61:0]        r_q_sq;
    logic               r_q_v;
    t_item              r_q_it;
    logic [TM_W-1:0]    r_tm_q;

    always_comb begin
        q_tm = d_quo[DIV_STEPS][TM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v <= 1'b0;
        end else if (i_en) begin
            r_q_v <= d_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q_sq <= 62'(q_tm) * 62'(q_tm);
            r_q_it <= d_it[DIV_STEPS];
            r_tm_q <= q_tm;
        end
    end

    // ---- square root, two radicand bits per stage
    logic               s_v    [SQ_STEPS+1];
    logic [SQ_IN_W-1:0] s_rad  [SQ_STEPS+1];
    logic [33:0]        s_rem  [SQ_STEPS+1];
    logic [31:0]        s_root [SQ_STEPS+1];
    t_item              s_it   [SQ_STEPS+1];
    logic [TM_W-1:0]    s_tm   [SQ_STEPS+1];

    always_comb begin
        s_v[0]    = r_q_v;
        s_rad[0]  = {(62'h1000_0000_0000_0000 + r_q_sq), 2'b00};
        s_rem[0]  = '0;
        s_root[0] = '0;
        s_it[0]   = r_q_it;
        s_tm[0]   = r_tm_q;
    end

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        gru_sqrt_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (s_v[g]),
            .i_rad   (s_rad[g]),
            .i_rem   (s_rem[g]),
            .i_root  (s_root[g]),
            .i_item  (s_it[g]),
            .i_tm    (s_tm[g]),
            .o_valid (s_v[g+1]),
            .o_rad   (s_rad[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_root  (s_root[g+1]),
            .o_item  (s_it[g+1]),
            .o_tm    (s_tm[g+1])
        );
    end

    // ---- reciprocal: k = 2^61 / r; r is in [2^31, 2^31*sqrt2], k <= 2^30
    // quotient below 2^31: top 31 numerator bits give zero quotient digits
    logic          k_v   [K_STEPS+1];
    logic [KW-1:0] k_rem [K_STEPS+1];
    logic [KW-1:0] k_den [K_STEPS+1];
    logic [KW-1:0] k_num [K_STEPS+1];
    logic [KW-1:0] k_quo [K_STEPS+1];
    t_item         k_it  [K_STEPS+1];
    logic [TM_W-1:0] k_tm [K_STEPS+1];

    // 2^61 = numerator; after 31 leading bits the remainder is 2^61 >> 31
    always_comb begin
        k_v[0]   = s_v[SQ_STEPS];
        k_rem[0] = KW'(64'd1 << 30);
        k_den[0] = {30'd0, s_root[SQ_STEPS]};
        k_num[0] = '0;
        k_quo[0] = '0;
        k_it[0]  = s_it[SQ_STEPS];
        k_tm[0]  = s_tm[SQ_STEPS];
    end

    for (genvar g = 0; g < K_STEPS; g++) begin : g_recip
        gru_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (k_v[g]),
            .i_rem   (k_rem[g]),
            .i_den   (k_den[g]),
            .i_num   (k_num[g]),
            .i_quo   (k_quo[g]),
            .i_item  (k_it[g]),
            .i_aux   (k_tm[g]),
            .o_valid (k_v[g+1]),
            .o_rem   (k_rem[g+1]),
            .o_den   (k_den[g+1]),
            .o_num   (k_num[g+1]),
            .o_quo   (k_quo[g+1]),
            .o_item  (k_it[g+1]),
            .o_aux   (k_tm[g+1])
        );
    end

    // ---- product tm*k
    logic        r_p_v;
    t_item       r_p_it;
    logic [31:0] r_p_k;
    logic [61:0] r_p_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (i_en) begin
            r_p_v <= k_v[K_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_k    <= k_quo[K_STEPS][31:0];
            r_p_prod <= 62'(k_tm[K_STEPS]) * 62'(k_quo[K_STEPS][30:0]);
            r_p_it   <= k_it[K_STEPS];
        end
    end

    // ---- place coefficients
    logic [31:0] n_o;
    t_item       n_out;

    always_comb begin
        n_o   = r_p_prod[61:30];
        n_out = r_p_it;
        if (r_p_it.gen) begin
            if (r_p_it.yzero) begin
                n_out.c = COEF_ONE;
                n_out.s = 32'sd0;
            end else begin
                if (r_p_it.neg) begin
                    n_o = 32'(-n_o);
                end
                if (r_p_it.ybig) begin
                    n_out.s = r_p_k;
                    n_out.c = n_o;
                end else begin
                    n_out.c = r_p_k;
                    n_out.s = n_o;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_item <= n_out;
        end
    end

    logic unused_ok;
    assign unused_ok = ^{d_aux[DIV_STEPS], d_rem[DIV_STEPS],
                         d_den[DIV_STEPS], d_num[DIV_STEPS], d_quo[DIV_STEPS][DW-1:TM_W],
                         s_rad[SQ_STEPS], s_rem[SQ_STEPS], k_rem[K_STEPS],
                         k_den[K_STEPS], k_num[K_STEPS], k_quo[K_STEPS][KW-1:32]};

endmodule

### rtl/core/gru_rotate.sv
// ----------------------------------------------------------------------------
// gru_rotate
// Pipelined rotation: four products, sum and round, saturate.
// ----------------------------------------------------------------------------
module gru_rotate
    import gru_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_item              i_item,
    output logic               o_valid,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic signed [31:0] o_c,
    output logic signed [31:0] o_s
);

    // stage A: products
    logic               r_a_v;
    logic signed [63:0] r_cx, r_sy, r_sx, r_cy;
    logic signed [31:0] r_a_c, r_a_s;
    // stage B: sums with rounding bias
    logic               r_b_v;
    logic signed [65:0] r_xs, r_ys;
    logic signed [31:0] r_b_c, r_b_s;

    logic signed [65:0] n_xs, n_ys;
    logic signed [35:0] n_xq, n_yq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_a_v   <= i_valid;
            r_b_v   <= r_a_v;
            o_valid <= r_b_v;
        end
    end

    // multiply
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx  <= i_item.c * i_item.x;
            r_sy  <= i_item.s * i_item.y;
            r_sx  <= i_item.s * i_item.x;
            r_cy  <= i_item.c * i_item.y;
            r_a_c <= i_item.c;
            r_a_s <= i_item.s;
        end
    end

    // add with half-LSB bias
    always_comb begin
        n_xs = 66'(r_cx) + 66'(r_sy) + 66'sd536870912;
        n_ys = 66'(r_cy) - 66'(r_sx) + 66'sd536870912;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xs  <= n_xs;
            r_ys  <= n_ys;
            r_b_c <= r_a_c;
            r_b_s <= r_a_s;
        end
    end

    // shift and saturate
    always_comb begin
        n_xq = r_xs[65:30];
        n_yq = r_ys[65:30];
    end

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -36'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x <= sat32(n_xq);
            o_y <= sat32(n_yq);
            o_c <= r_b_c;
            o_s <= r_b_s;
        end
    end

endmodule

### rtl/core/givens_rotation_unit_core.sv
// Throughput: one beat per cycle; the whole pipeline advances when the
// output register is empty or being taken.
// The ratio divide, square root and reciprocal resolve one bit per stage.
// Reset: synchronous, active low; clears all valid bits, data unaffected.
// ----------------------------------------------------------------------------
// givens_rotation_unit_core
// Givens plane rotation with optional coefficient generation.
// ----------------------------------------------------------------------------
module givens_rotation_unit_core
    import gru_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,  // x_in, y_in, cos_in, sin_in
    input  logic          s_axis_tuser,  // mode
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata   // x_out, y_out, cos_out, sin_out
);

    logic  w_en;
    t_item n_item;
    logic  g_v;
    t_item g_item;
    logic  o_v;
    logic signed [31:0] o_x, o_y, o_c, o_s;

    // advance when the last stage is free or drained
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = o_v;
    assign m_axis_tdata  = {o_s, o_c, o_y, o_x};

    always_comb begin
        n_item       = '0;
        n_item.gen   = (s_axis_tuser == MODE_GEN);
        n_item.x     = s_axis_tdata[31:0];
        n_item.y     = s_axis_tdata[63:32];
        n_item.c     = s_axis_tdata[95:64];
        n_item.s     = s_axis_tdata[127:96];
    end

    gru_coef_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_item  (n_item),
        .o_valid (g_v),
        .o_item  (g_item)
    );

    gru_rotate u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (g_v),
        .i_item  (g_item),
        .o_valid (o_v),
        .o_x     (o_x),
        .o_y     (o_y),
        .o_c     (o_c),
        .o_s     (o_s)
    );

endmodule

### rtl/core/gru_checker.sv
// ----------------------------------------------------------------------------
// gru_checker
// Port-level checks of the rotation unit.
// ----------------------------------------------------------------------------
module gru_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // hold output beat while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed under stall");

    // ready follows the output stall
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready not tied to output state");

    // nothing emerges right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind givens_rotation_unit_core gru_checker u_checker (.*);

### verif/givens_rotation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// givens_rotation_checker
// Watches both stream channels of the Givens rotation unit, computes the
// expected rotated pair and coefficients for every accepted input beat, and
// compares each output beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module givens_rotation_checker
    import gru_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    input  logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,  // x_in, y_in, cos_in, sin_in
    input  logic          s_axis_tuser,  // mode
    input  logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic [127:0]  m_axis_tdata,  // x_out, y_out, cos_out, sin_out
    output int            o_fail_count,
    output int            o_pending,
    output int            o_results_seen
);

    logic [127:0] rotated_q[$];

    // Integer square root, floor, of a 64-bit radicand
    function automatic logic [63:0] isqrt64(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // a*b +/- c*d, rounded at bit 30 with ties upward, saturated to 32 bits
    function automatic logic signed [31:0] rot_sum(logic signed [31:0] a,
        logic signed [31:0] b, logic signed [31:0] c, logic signed [31:0] d,
        logic sub);
        logic signed [95:0] acc;
        logic signed [95:0] cd;
        cd = 96'(c) * 96'(d);
        if (sub) cd = -cd;
        acc = 96'(a) * 96'(b) + cd + (96'sd1 <<< 29);
        acc = acc >>> 30;
        if (acc > 96'sd2147483647) return 32'sh7fff_ffff;
        if (acc < -96'sd2147483648) return 32'sh8000_0000;
        return acc[31:0];
    endfunction

    // Expected output beat for one input beat
    function automatic logic [127:0] predict_rotation(logic mode, logic [127:0] d);
        logic signed [31:0] x, y, c, s;
        logic [31:0] ax, ay, big, sml;
        logic [63:0] tm, r, k, o;
        logic ybig, neg;
        x = d[31:0];
        y = d[63:32];
        c = d[95:64];
        s = d[127:96];
        if (t_mode'(mode) == MODE_GEN) begin
            if (y == 0) begin
                c = COEF_ONE;
                s = 0;
            end else begin
                ax = x[31] ? -x : x;
                ay = y[31] ? -y : y;
                ybig = ay > ax;
                big = ybig ? ay : ax;
                sml = ybig ? ax : ay;
                neg = x[31] != y[31];
                tm = (64'(sml) << 30) / 64'(big);
                r = isqrt64(((64'd1 << 60) + tm * tm) << 2);
                k = (64'd1 << 61) / r;
                o = (tm * k) >> 30;
                if (neg && sml != 0) o = -o;
                if (ybig) begin
                    s = k[31:0];
                    c = o[31:0];
                end else begin
                    c = k[31:0];
                    s = o[31:0];
                end
            end
        end
        return {s, c, rot_sum(c, y, s, x, 1'b1), rot_sum(c, x, s, y, 1'b0)};
    endfunction

    assign o_pending = rotated_q.size();

    // Predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        logic [127:0] exp_beat;
        if (!i_rst_n) begin
            rotated_q.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                rotated_q = {rotated_q, predict_rotation(s_axis_tuser, s_axis_tdata)};
            if (m_axis_tvalid && m_axis_tready) begin
                o_results_seen <= o_results_seen + 1;
                if (rotated_q.size() == 0) begin
                    $error("output beat with no prediction: %h", m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_beat = rotated_q.pop_front();
                    if (exp_beat != m_axis_tdata) begin
                        if (exp_beat[31:0] != m_axis_tdata[31:0])
                            $error("x_out expected %h got %h", exp_beat[31:0],
                                m_axis_tdata[31:0]);
                        if (exp_beat[63:32] != m_axis_tdata[63:32])
                            $error("y_out expected %h got %h", exp_beat[63:32],
                                m_axis_tdata[63:32]);
                        if (exp_beat[95:64] != m_axis_tdata[95:64])
                            $error("cos_out expected %h got %h", exp_beat[95:64],
                                m_axis_tdata[95:64]);
                        if (exp_beat[127:96] != m_axis_tdata[127:96])
                            $error("sin_out expected %h got %h", exp_beat[127:96],
                                m_axis_tdata[127:96]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### verif/tb_givens_rotation_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_givens_rotation_unit_core
// Drives directed corner pairs and random apply/generate beats with bursty
// input and random output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_givens_rotation_unit_core
    import gru_pkg::*;
();

    localparam int LATENCY   = 101;
    localparam int N_RANDOM  = 2000;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata;  // x_in, y_in, cos_in, sin_in
    logic          s_axis_tuser;  // mode
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [127:0]  m_axis_tdata;  // x_out, y_out, cos_out, sin_out
    int            fail_count;
    int            pending;
    int            results_seen;
    int            n_gen;
    int            n_apply;

    givens_rotation_unit_core DUT (.*);

    givens_rotation_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Output stalls: alternate calm and choppy stretches
    initial m_axis_tready = 1'b0;
    always @(posedge i_clk) begin
        int phase;
        phase = ($urandom_range(0, 3) == 0) ? 1 : 0;
        repeat ($urandom_range(20, 200)) begin
            if (phase == 1) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 2) != 0);
            @(posedge i_clk);
        end
    end

    // Pick a pair element, biased toward corner values
    function automatic logic [31:0] pick_elem();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return $urandom_range(0, 255) - 128;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return COEF_ONE;
            1: return -COEF_ONE;
            2: return $urandom();
            default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        endcase
    endfunction

    // Send one beat and hold it until accepted
    task automatic send_beat(t_mode m, logic [31:0] x, logic [31:0] y,
        logic [31:0] c, logic [31:0] s);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= m;
        s_axis_tdata <= {s, c, y, x};
        if (m == MODE_GEN) n_gen++;
        else n_apply++;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic idle_gap(int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    initial begin
        int burst;
        int sent;
        n_gen = 0;
        n_apply = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = 1'b0;
        s_axis_tdata = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero y, zero x, equal magnitudes, extremes, wild coefficients
        send_beat(MODE_GEN, 32'h0001_0000, 32'd0, 32'd0, 32'd0);
        send_beat(MODE_GEN, 32'h8000_0000, 32'd0, 32'h1234_5678, 32'd5);
        send_beat(MODE_GEN, 32'd0, 32'h0003_0000, 32'd0, 32'd0);
        send_beat(MODE_GEN, 32'd0, 32'h8000_0000, 32'd0, 32'd0);
        send_beat(MODE_GEN, 32'h0002_0000, 32'h0002_0000, 32'd0, 32'd0);
        send_beat(MODE_GEN, 32'h0002_0000, 32'hfffe_0000, 32'd0, 32'd0);
        send_beat(MODE_GEN, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
        send_beat(MODE_GEN, 32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'd0);
        send_beat(MODE_GEN, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd0);
        send_beat(MODE_GEN, 32'd1, 32'h7fff_ffff, 32'd0, 32'd0);
        send_beat(MODE_GEN, 32'hffff_ffff, 32'd1, 32'd0, 32'd0);
        send_beat(MODE_APPLY, 32'h7fff_ffff, 32'h7fff_ffff, COEF_ONE, COEF_ONE);
        send_beat(MODE_APPLY, 32'h8000_0000, 32'h8000_0000, COEF_ONE, COEF_ONE);
        send_beat(MODE_APPLY, 32'h8000_0000, 32'h7fff_ffff, -COEF_ONE, COEF_ONE);
        send_beat(MODE_APPLY, 32'h1234_5678, 32'h9abc_def0, 32'h7fff_ffff, 32'h8000_0000);
        send_beat(MODE_APPLY, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(MODE_APPLY, 32'd1, 32'd0, 32'h2000_0000, 32'd0);
        send_beat(MODE_APPLY, 32'hffff_ffff, 32'd0, 32'h2000_0000, 32'd0);
        send_beat(MODE_APPLY, 32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0);

        // Hold off until the pipeline has drained
        idle_gap(1);
        while (pending != 0) @(posedge i_clk);

        // Random bursts with random gaps
        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                send_beat(t_mode'($urandom_range(0, 1)), pick_elem(), pick_elem(),
                    pick_coef(), pick_coef());
                sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 15));
        end
        idle_gap(1);

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("Covered %0d generate and %0d apply beats, %0d results checked.",
            n_gen, n_apply, results_seen);
        if (fail_count == 0 && pending == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule
